### hw/rtl/pid_pkg.sv
// ----------------------------------------------------------------------------
// PID step package
// Shared constants and configuration register indices for the PID step block.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_INTEGRAL = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_LOW     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_HIGH    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_LOW       = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_HIGH      = 3'd6;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

endpackage

### hw/rtl/pid_integ.sv
// ----------------------------------------------------------------------------
// PID integrator stage
// Takes items, updates and clamps or clears the integrator, and holds the samples
// of an update item together with the new integrator value for the next stage.
// ----------------------------------------------------------------------------
module pid_integ #(
  parameter int SAMPLE_WIDTH = pid_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = pid_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     kind,
  input  logic signed [SAMPLE_WIDTH-1:0]           err_value,
  input  logic signed [SAMPLE_WIDTH-1:0]           plant_rate,
  input  logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] integ_low,
  input  logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] integ_high,
  input  logic                                     down_ready,
  output logic                                     s1_valid,
  output logic signed [SAMPLE_WIDTH-1:0]           s1_err,
  output logic signed [SAMPLE_WIDTH-1:0]           s1_rate,
  output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] s1_integ
);
  import pid_pkg::*;

  localparam int IW = SAMPLE_WIDTH + FRAC_BITS;

  logic signed [IW-1:0] integrator;
  logic signed [IW-1:0] integrator_next;
  logic signed [IW:0]   acc;
  logic signed [IW:0]   acc_hi;
  logic signed [IW:0]   acc_lo;
  logic signed [IW:0]   high_ext;
  logic signed [IW:0]   low_ext;
  logic                 s1_load;
  logic                 accept;

  assign s1_load  = !s1_valid || down_ready;
  assign in_stall = !s1_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    acc      = {integrator[IW-1], integrator}
             + {{(IW + 1 - SAMPLE_WIDTH){err_value[SAMPLE_WIDTH-1]}}, err_value};
    high_ext = {integ_high[IW-1], integ_high};
    low_ext  = {integ_low[IW-1], integ_low};
    acc_hi   = (acc > high_ext) ? high_ext : acc;
    acc_lo   = (acc_hi < low_ext) ? low_ext : acc_hi;
    integrator_next = acc_lo[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (accept) begin
      if (kind == KIND_CLEAR) begin
        integrator <= '0;
      end else begin
        integrator <= integrator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= accept && (kind == KIND_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_UPDATE)) begin
      s1_err   <= err_value;
      s1_rate  <= plant_rate;
      s1_integ <= integrator_next;
    end
  end

endmodule

### hw/rtl/pid_mac.sv
// ----------------------------------------------------------------------------
// PID output stage
// Forms the weighted sum of error, integrator and plant derivative, floors it
// to an integer, saturates it and holds it in the output register.
// ----------------------------------------------------------------------------
module pid_mac #(
  parameter int SAMPLE_WIDTH = pid_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = pid_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s1_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]           s1_err,
  input  logic signed [SAMPLE_WIDTH-1:0]           s1_rate,
  input  logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] s1_integ,
  output logic                                     up_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]           gain_prop,
  input  logic signed [SAMPLE_WIDTH-1:0]           gain_integral,
  input  logic signed [SAMPLE_WIDTH-1:0]           gain_deriv,
  input  logic signed [SAMPLE_WIDTH-1:0]           out_low,
  input  logic signed [SAMPLE_WIDTH-1:0]           out_high,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           drive
);
  import pid_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int IW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int PW = SW + IW + 2;

  logic signed [2*SW-1:0]  prod_p;
  logic signed [SW+IW-1:0] prod_i;
  logic signed [2*SW-1:0]  prod_d;
  logic signed [PW-1:0]    sum;
  logic signed [PW-1:0]    shifted;
  logic signed [PW-1:0]    lim_hi;
  logic signed [PW-1:0]    lim_lo;
  logic signed [PW-1:0]    out_hi_ext;
  logic signed [PW-1:0]    out_lo_ext;

  assign up_ready = !out_valid || !out_stall;

  always_comb begin
    prod_p     = gain_prop * s1_err;
    prod_i     = gain_integral * s1_integ;
    prod_d     = gain_deriv * s1_rate;
    sum        = {{(PW - 2*SW){prod_p[2*SW-1]}}, prod_p}
               + {{(PW - SW - IW){prod_i[SW+IW-1]}}, prod_i}
               - {{(PW - 2*SW){prod_d[2*SW-1]}}, prod_d};
    shifted    = sum >>> (2 * FRAC_BITS);
    out_hi_ext = {{(PW - SW){out_high[SW-1]}}, out_high};
    out_lo_ext = {{(PW - SW){out_low[SW-1]}}, out_low};
    lim_hi     = (shifted > out_hi_ext) ? out_hi_ext : shifted;
    lim_lo     = (lim_hi < out_lo_ext) ? out_lo_ext : lim_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && s1_valid) begin
      drive <= lim_lo[SW-1:0];
    end
  end

endmodule

### hw/rtl/pid_step_with_integral_clamp.sv
// ----------------------------------------------------------------------------
// PID step with integral clamp
// Top level: configuration registers, integrator stage and output stage.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle while in_stall is low and
// delivers the drive value of an update item via the stage and output
// registers. The integrator is added to and clamped at the edge that accepts
// the item, so consecutive updates see each other's result with no gap; the
// three products, their sum, the floor shift and the output saturation sit
// in the second stage. A clear item zeroes the integrator and yields no
// result. Configuration writes must be made while no item is in flight.
module pid_step_with_integral_clamp #(
  parameter int SAMPLE_WIDTH = pid_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = pid_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [pid_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [SAMPLE_WIDTH+FRAC_BITS-1:0]        cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     kind,
  input  logic signed [SAMPLE_WIDTH-1:0]           err_value,
  input  logic signed [SAMPLE_WIDTH-1:0]           plant_rate,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           drive
);
  import pid_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int IW = SAMPLE_WIDTH + FRAC_BITS;

  logic signed [SW-1:0] gain_prop;
  logic signed [SW-1:0] gain_integral;
  logic signed [SW-1:0] gain_deriv;
  logic signed [IW-1:0] integ_low;
  logic signed [IW-1:0] integ_high;
  logic signed [SW-1:0] out_low;
  logic signed [SW-1:0] out_high;

  logic                 s1_valid;
  logic signed [SW-1:0] s1_err;
  logic signed [SW-1:0] s1_rate;
  logic signed [IW-1:0] s1_integ;
  logic                 up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= '0;
      gain_integral <= '0;
      gain_deriv    <= '0;
      integ_low     <= '0;
      integ_high    <= '0;
      out_low       <= '0;
      out_high      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_PROP:     gain_prop     <= cfg_data[SW-1:0];
        REG_GAIN_INTEGRAL: gain_integral <= cfg_data[SW-1:0];
        REG_GAIN_DERIV:    gain_deriv    <= cfg_data[SW-1:0];
        REG_INTEG_LOW:     integ_low     <= cfg_data;
        REG_INTEG_HIGH:    integ_high    <= cfg_data;
        REG_OUT_LOW:       out_low       <= cfg_data[SW-1:0];
        REG_OUT_HIGH:      out_high      <= cfg_data[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  pid_integ #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_integ (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .err_value (err_value),
    .plant_rate(plant_rate),
    .integ_low (integ_low),
    .integ_high(integ_high),
    .down_ready(up_ready),
    .s1_valid  (s1_valid),
    .s1_err    (s1_err),
    .s1_rate   (s1_rate),
    .s1_integ  (s1_integ)
  );

  pid_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_err       (s1_err),
    .s1_rate      (s1_rate),
    .s1_integ     (s1_integ),
    .up_ready     (up_ready),
    .gain_prop    (gain_prop),
    .gain_integral(gain_integral),
    .gain_deriv   (gain_deriv),
    .out_low      (out_low),
    .out_high     (out_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive        (drive)
  );

endmodule

### hw/rtl/pid_chk.sv
// ----------------------------------------------------------------------------
// PID step checker
// Port-level assertions for the PID step block, bound to the top level.
// ----------------------------------------------------------------------------
module pid_chk #(
  parameter int SAMPLE_WIDTH = pid_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    kind,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] drive
);
  import pid_pkg::*;

  logic in_accept;

  assign in_accept = in_valid && !in_stall;

  // Nothing comes out straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A result appearing at an empty output comes from an update item that was
  // accepted and passed through the integrator stage register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && (kind == KIND_UPDATE), 2))
    else $error("result without a matching update item");

  // With the output empty the input side is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive))
    else $error("stalled result changed");

endmodule

bind pid_step_with_integral_clamp pid_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_pid_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .kind     (kind),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .drive    (drive)
);
